### design/assert_macros.svh
// assertion helpers shared by the scheduler modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define CHECK_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("scheduler check failed");

// antecedent implies consequent at the next edge
`define CHECK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler sequence check failed");

`endif

### design/pprs_pkg.sv
package pprs_pkg;

  // task states as reported on the result channel
  localparam logic [2:0] TS_NEW   = 3'd0;
  localparam logic [2:0] TS_READY = 3'd1;
  localparam logic [2:0] TS_RUN   = 3'd2;
  localparam logic [2:0] TS_WAIT  = 3'd3;
  localparam logic [2:0] TS_TERM  = 3'd4;

  localparam logic [15:0] TIME_SLICE_RST = 16'd100;

  // input op codes
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ARR,
    S_RL_FIFO,
    S_RL_TASK,
    S_RL_UPD,
    S_CH_RD,
    S_CH_UPD,
    S_DISP,
    S_DISP_RUN,
    S_FIN
  } state_t;

  // per-task record held in the task memory
  typedef struct packed {
    logic [15:0] rem_work;
    logic [15:0] io_period;
    logic [15:0] io_length;
    logic [15:0] ticks_to_io;
    logic [15:0] io_left;
  } task_rec_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic arr_do;
    logic rl_issue;
    logic rl_fetch;
    logic rl_upd;
    logic ch_rd;
    logic ch_upd;
    logic disp_eval;
    logic disp_run;
    logic fin;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rl_done;
    logic cpu_busy;
    logic disp_go;
  } status_t;

endpackage

### design/pprs_ram.sv
module pprs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/pprs_ctrl.sv
`include "assert_macros.svh"

module pprs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_op,
  input  pprs_pkg::status_t  status,
  output pprs_pkg::cmd_t     cmd,
  output logic               busy
);

  pprs_pkg::state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pprs_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = (in_op == pprs_pkg::OP_TICK) ? pprs_pkg::S_RL_FIFO : pprs_pkg::S_ARR;
        end
      end
      pprs_pkg::S_ARR:     state_nxt = pprs_pkg::S_FIN;
      pprs_pkg::S_RL_FIFO: begin
        if (status.rl_done) begin
          state_nxt = status.cpu_busy ? pprs_pkg::S_CH_RD : pprs_pkg::S_DISP;
        end else begin
          state_nxt = pprs_pkg::S_RL_TASK;
        end
      end
      pprs_pkg::S_RL_TASK:  state_nxt = pprs_pkg::S_RL_UPD;
      pprs_pkg::S_RL_UPD:   state_nxt = pprs_pkg::S_RL_FIFO;
      pprs_pkg::S_CH_RD:    state_nxt = pprs_pkg::S_CH_UPD;
      pprs_pkg::S_CH_UPD:   state_nxt = pprs_pkg::S_DISP;
      pprs_pkg::S_DISP:     state_nxt = status.disp_go ? pprs_pkg::S_DISP_RUN : pprs_pkg::S_FIN;
      pprs_pkg::S_DISP_RUN: state_nxt = pprs_pkg::S_FIN;
      pprs_pkg::S_FIN:      state_nxt = pprs_pkg::S_IDLE;
      default:              state_nxt = pprs_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    unique case (state_r)
      pprs_pkg::S_IDLE:     cmd.accept    = start;
      pprs_pkg::S_ARR:      cmd.arr_do    = 1'b1;
      pprs_pkg::S_RL_FIFO:  cmd.rl_issue  = 1'b1;
      pprs_pkg::S_RL_TASK:  cmd.rl_fetch  = 1'b1;
      pprs_pkg::S_RL_UPD:   cmd.rl_upd    = 1'b1;
      pprs_pkg::S_CH_RD:    cmd.ch_rd     = 1'b1;
      pprs_pkg::S_CH_UPD:   cmd.ch_upd    = 1'b1;
      pprs_pkg::S_DISP:     cmd.disp_eval = 1'b1;
      pprs_pkg::S_DISP_RUN: cmd.disp_run  = 1'b1;
      pprs_pkg::S_FIN:      cmd.fin       = 1'b1;
      default:              cmd           = '0;
    endcase
  end

  assign busy = (state_r != pprs_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pprs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `CHECK_NEXT(a_fin_to_idle, clk, rst_n, state_r == pprs_pkg::S_FIN, state_r == pprs_pkg::S_IDLE)
  `CHECK_NEXT(a_accept_leaves_idle, clk, rst_n, cmd.accept, busy)

endmodule

### design/pprs_dp.sv
`include "assert_macros.svh"

module pprs_dp #(
  parameter int MAX_TASKS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pprs_pkg::cmd_t    cmd,
  output pprs_pkg::status_t status,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  logic              in_op,
  input  logic [3:0]        in_task_id,
  input  logic [15:0]       in_cpu_time,
  input  logic [15:0]       in_io_period,
  input  logic [15:0]       in_io_length,
  output logic              out_valid,
  output logic [23:0]       out_event_time,
  output logic [3:0]        out_event_task,
  output logic [1:0]        out_from_state,
  output logic [2:0]        out_to_state,
  output logic              out_last
);

  localparam int TW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int IW = (TW > 4) ? TW : 4;
  localparam int RW = $bits(pprs_pkg::task_rec_t);

  // control registers
  logic [MAX_TASKS-1:0] ready_r, ready_nxt;
  logic [MAX_TASKS-1:0] wait_r, wait_nxt;
  logic [CW-1:0]        wcnt_r, wcnt_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        i_r, i_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [TW-1:0]        run_r, run_nxt;
  logic                 busy_r, busy_nxt;
  logic [15:0]          slice_r, slice_nxt;
  logic [23:0]          now_r, now_nxt;
  logic [15:0]          tslice_r, tslice_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic                 out_v_r, out_v_nxt;
  logic                 op_tick_r;

  // payload registers
  logic [3:0]           id_in_r;
  logic [15:0]          cpu_r, per_r, len_r;
  logic [TW-1:0]        cur_r, cur_nxt;
  logic [TW-1:0]        best_r, best_nxt;
  logic [3:0]           pend_task_r, pend_task_nxt;
  logic [2:0]           pend_from_r, pend_from_nxt;
  logic [2:0]           pend_to_r, pend_to_nxt;
  logic [23:0]          pend_time_r, pend_time_nxt;
  logic [23:0]          o_time_r, o_time_nxt;
  logic [3:0]           o_task_r, o_task_nxt;
  logic [2:0]           o_from_r, o_from_nxt;
  logic [2:0]           o_to_r, o_to_nxt;
  logic                 o_last_r, o_last_nxt;

  // memory ports
  logic                 t_we, f_we;
  logic [TW-1:0]        t_waddr, t_raddr, f_waddr, f_raddr;
  pprs_pkg::task_rec_t  t_wdata, t_rdata;
  logic [TW-1:0]        f_wdata, f_rdata;
  logic [RW-1:0]        t_rdata_raw;

  // result staging
  logic                 emit;
  logic [TW-1:0]        em_task;
  logic [2:0]           em_from, em_to;

  logic [IW-1:0]        arr_ext;
  logic [TW-1:0]        arr_id;
  logic                 arr_ok;
  logic [TW-1:0]        first_rdy;
  logic                 go;

  pprs_ram #(.WIDTH(RW), .DEPTH(MAX_TASKS)) u_task_ram (
    .clk  (clk),
    .we   (t_we),
    .waddr(t_waddr),
    .wdata(t_wdata),
    .raddr(t_raddr),
    .rdata(t_rdata_raw)
  );
  assign t_rdata = pprs_pkg::task_rec_t'(t_rdata_raw);

  pprs_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_wait_fifo (
    .clk  (clk),
    .we   (f_we),
    .waddr(f_waddr),
    .wdata(f_wdata),
    .raddr(f_raddr),
    .rdata(f_rdata)
  );

  function automatic logic [3:0] to_task4(input logic [TW-1:0] id);
    logic [IW-1:0] ext;
    ext = IW'(id);
    return ext[3:0];
  endfunction

  // lowest set bit of the ready mask
  function automatic logic [TW-1:0] find_first(input logic [MAX_TASKS-1:0] m);
    logic [TW-1:0] b;
    b = '0;
    for (int n = MAX_TASKS - 1; n >= 0; n--) begin
      if (m[n]) b = TW'(n);
    end
    return b;
  endfunction

  assign arr_ext   = IW'(id_in_r);
  assign arr_id    = arr_ext[TW-1:0];
  assign arr_ok    = (32'(id_in_r) < 32'(MAX_TASKS)) && !ready_r[arr_id] &&
                     !(busy_r && run_r == arr_id) && !wait_r[arr_id];
  assign first_rdy = find_first(ready_r);
  assign go        = (ready_r != '0) &&
                     (!busy_r || first_rdy < run_r || slice_r == tslice_r);

  assign status.rl_done  = (i_r == cnt_r);
  assign status.cpu_busy = busy_r;
  assign status.disp_go  = go;

  // memory read address selection
  always_comb begin
    f_raddr = i_r[TW-1:0];
    t_raddr = cmd.rl_fetch ? f_rdata : run_r;
  end

  // sequencing datapath
  always_comb begin
    ready_nxt     = ready_r;
    wait_nxt      = wait_r;
    wcnt_nxt      = wcnt_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    run_nxt       = run_r;
    busy_nxt      = busy_r;
    slice_nxt     = slice_r;
    now_nxt       = now_r;
    tslice_nxt    = tslice_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    t_we          = 1'b0;
    t_waddr       = cur_r;
    t_wdata       = t_rdata;
    f_we          = 1'b0;
    f_waddr       = k_r[TW-1:0];
    f_wdata       = cur_r;
    emit          = 1'b0;
    em_task       = cur_r;
    em_from       = pprs_pkg::TS_READY;
    em_to         = pprs_pkg::TS_RUN;

    if (cfg_we) tslice_nxt = cfg_wdata;

    // start of an item: snapshot the waiter count
    if (cmd.accept) begin
      cnt_nxt = wcnt_r;
      i_nxt   = '0;
      k_nxt   = '0;
    end

    // task arrival
    if (cmd.arr_do && arr_ok) begin
      t_we      = 1'b1;
      t_waddr   = arr_id;
      t_wdata   = '{rem_work: cpu_r, io_period: per_r, io_length: len_r,
                    ticks_to_io: per_r, io_left: 16'd0};
      ready_nxt[arr_id] = 1'b1;
      emit      = 1'b1;
      em_task   = arr_id;
      em_from   = pprs_pkg::TS_NEW;
      em_to     = pprs_pkg::TS_READY;
    end

    // release scan: step through the waiter queue
    if (cmd.rl_issue) begin
      if (i_r == cnt_r) begin
        wcnt_nxt = k_r;
      end else begin
        i_nxt = i_r + 1'b1;
      end
    end
    if (cmd.rl_fetch) cur_nxt = f_rdata;
    if (cmd.rl_upd) begin
      t_we    = 1'b1;
      t_waddr = cur_r;
      if (t_rdata.io_left > 16'd1) begin
        t_wdata.io_left = t_rdata.io_left - 16'd1;
        f_we    = 1'b1;
        f_waddr = k_r[TW-1:0];
        f_wdata = cur_r;
        k_nxt   = k_r + 1'b1;
      end else begin
        t_wdata.io_left = 16'd0;
        ready_nxt[cur_r] = 1'b1;
        wait_nxt[cur_r]  = 1'b0;
        emit    = 1'b1;
        em_task = cur_r;
        em_from = pprs_pkg::TS_WAIT;
        em_to   = pprs_pkg::TS_READY;
      end
    end

    // charge one tick to the running task
    if (cmd.ch_upd) begin
      t_we    = 1'b1;
      t_waddr = run_r;
      if (t_rdata.rem_work != 16'd0) t_wdata.rem_work = t_rdata.rem_work - 16'd1;
      if (t_rdata.io_period != 16'd0 && t_rdata.ticks_to_io != 16'd0) begin
        t_wdata.ticks_to_io = t_rdata.ticks_to_io - 16'd1;
      end
      if (slice_r != 16'hFFFF) slice_nxt = slice_r + 16'd1;
      if (t_wdata.rem_work == 16'd0) begin
        emit      = 1'b1;
        em_task   = run_r;
        em_from   = pprs_pkg::TS_RUN;
        em_to     = pprs_pkg::TS_TERM;
        busy_nxt  = 1'b0;
        slice_nxt = '0;
      end else if (t_rdata.io_period != 16'd0 && t_wdata.ticks_to_io == 16'd0) begin
        emit      = 1'b1;
        em_task   = run_r;
        em_from   = pprs_pkg::TS_RUN;
        em_to     = pprs_pkg::TS_WAIT;
        t_wdata.io_left     = t_rdata.io_length;
        t_wdata.ticks_to_io = t_rdata.io_period;
        if (32'(wcnt_r) < 32'(MAX_TASKS)) begin
          f_we     = 1'b1;
          f_waddr  = wcnt_r[TW-1:0];
          f_wdata  = run_r;
          wcnt_nxt = wcnt_r + 1'b1;
          wait_nxt[run_r] = 1'b1;
        end
        busy_nxt  = 1'b0;
        slice_nxt = '0;
      end
    end

    // dispatch decision, preempting the running task if needed
    if (cmd.disp_eval) begin
      best_nxt = first_rdy;
      if (go && busy_r) begin
        ready_nxt[run_r] = 1'b1;
        emit    = 1'b1;
        em_task = run_r;
        em_from = pprs_pkg::TS_RUN;
        em_to   = pprs_pkg::TS_READY;
      end
    end
    if (cmd.disp_run) begin
      ready_nxt[best_r] = 1'b0;
      run_nxt   = best_r;
      busy_nxt  = 1'b1;
      slice_nxt = '0;
      emit      = 1'b1;
      em_task   = best_r;
      em_from   = pprs_pkg::TS_READY;
      em_to     = pprs_pkg::TS_RUN;
    end

    // time advances once at the end of a tick
    if (cmd.fin && op_tick_r) now_nxt = now_r + 24'd1;
  end

  // result staging: hold one result back so the final one can carry last
  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_task_nxt = pend_task_r;
    pend_from_nxt = pend_from_r;
    pend_to_nxt   = pend_to_r;
    pend_time_nxt = pend_time_r;
    out_v_nxt     = 1'b0;
    o_time_nxt    = o_time_r;
    o_task_nxt    = o_task_r;
    o_from_nxt    = o_from_r;
    o_to_nxt      = o_to_r;
    o_last_nxt    = o_last_r;
    if (emit) begin
      if (pend_v_r) begin
        out_v_nxt  = 1'b1;
        o_time_nxt = pend_time_r;
        o_task_nxt = pend_task_r;
        o_from_nxt = pend_from_r;
        o_to_nxt   = pend_to_r;
        o_last_nxt = 1'b0;
      end
      pend_v_nxt    = 1'b1;
      pend_task_nxt = to_task4(em_task);
      pend_from_nxt = em_from;
      pend_to_nxt   = em_to;
      pend_time_nxt = now_r;
    end
    if (cmd.fin && pend_v_r) begin
      out_v_nxt  = 1'b1;
      o_time_nxt = pend_time_r;
      o_task_nxt = pend_task_r;
      o_from_nxt = pend_from_r;
      o_to_nxt   = pend_to_r;
      o_last_nxt = 1'b1;
      pend_v_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r  <= '0;
      wait_r   <= '0;
      wcnt_r   <= '0;
      cnt_r    <= '0;
      i_r      <= '0;
      k_r      <= '0;
      run_r    <= '0;
      busy_r   <= 1'b0;
      slice_r  <= '0;
      now_r    <= '0;
      tslice_r <= pprs_pkg::TIME_SLICE_RST;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      ready_r  <= ready_nxt;
      wait_r   <= wait_nxt;
      wcnt_r   <= wcnt_nxt;
      cnt_r    <= cnt_nxt;
      i_r      <= i_nxt;
      k_r      <= k_nxt;
      run_r    <= run_nxt;
      busy_r   <= busy_nxt;
      slice_r  <= slice_nxt;
      now_r    <= now_nxt;
      tslice_r <= tslice_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      id_in_r <= in_task_id;
      cpu_r   <= in_cpu_time;
      per_r   <= in_io_period;
      len_r   <= in_io_length;
    end
    cur_r       <= cur_nxt;
    best_r      <= best_nxt;
    pend_task_r <= pend_task_nxt;
    pend_from_r <= pend_from_nxt;
    pend_to_r   <= pend_to_nxt;
    pend_time_r <= pend_time_nxt;
    o_time_r    <= o_time_nxt;
    o_task_r    <= o_task_nxt;
    o_from_r    <= o_from_nxt;
    o_to_r      <= o_to_nxt;
    o_last_r    <= o_last_nxt;
  end

  // remember whether the current item is a tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_tick_r <= 1'b0;
    end else if (cmd.accept) begin
      op_tick_r <= (in_op == pprs_pkg::OP_TICK);
    end
  end

  assign out_valid      = out_v_r;
  assign out_event_time = o_time_r;
  assign out_event_task = o_task_r;
  assign out_from_state = o_from_r[1:0];
  assign out_to_state   = o_to_r;
  assign out_last       = o_last_r;

  `CHECK_ALWAYS(a_ready_wait_disjoint, clk, rst_n, (ready_r & wait_r) == '0)
  `CHECK_ALWAYS(a_running_not_ready, clk, rst_n, !busy_r || !ready_r[run_r] || cmd.disp_run)
  `CHECK_ALWAYS(a_wait_count_bound, clk, rst_n, 32'(wcnt_r) <= 32'(MAX_TASKS))
  `CHECK_ALWAYS(a_wait_count_matches, clk, rst_n, 32'($countones(wait_r)) <= 32'(wcnt_r))

endmodule

### design/preemptive_priority_rr_scheduler_unit.sv
// Preemptive priority scheduler with a round-robin quantum.
// Input channel: an item is taken on a rising edge with start high and busy
// low. in_op selects a task arrival (loads cpu_time, io_period, io_length for
// in_task_id) or one scheduler tick.
// Result channel: each state transition is one beat, shown for one cycle with
// out_valid high; out_last marks the final beat of an item. The receiver
// cannot stall; beats leave at most one per cycle.
// Config: cfg_we with cfg_wdata writes time_slice (reset 100). The user must
// write it only while idle; the block itself does not enforce this.
// Sequencing: an arrival holds busy through an arrival and a wrap-up state.
// A tick reads the queue entry, reads the task record and writes it back for
// each task in I/O wait (all through one memory port each), then does the
// last queue check, charge, dispatch and wrap-up; the final beat appears in
// the first cycle with busy low. Items may follow as soon as busy is low.
// Reset: synchronous active low; no task is ready, waiting or running, time
// is zero. Task records need no clearing.
module preemptive_priority_rr_scheduler_unit #(
  parameter int MAX_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [3:0]  in_task_id,
  input  logic [15:0] in_cpu_time,
  input  logic [15:0] in_io_period,
  input  logic [15:0] in_io_length,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        out_valid,
  output logic [23:0] out_event_time,
  output logic [3:0]  out_event_task,
  output logic [1:0]  out_from_state,
  output logic [2:0]  out_to_state,
  output logic        out_last
);

  pprs_pkg::cmd_t    cmd;
  pprs_pkg::status_t status;

  // sequencer
  pprs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  // task state and result datapath
  pprs_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_op         (in_op),
    .in_task_id    (in_task_id),
    .in_cpu_time   (in_cpu_time),
    .in_io_period  (in_io_period),
    .in_io_length  (in_io_length),
    .out_valid     (out_valid),
    .out_event_time(out_event_time),
    .out_event_task(out_event_task),
    .out_from_state(out_from_state),
    .out_to_state  (out_to_state),
    .out_last      (out_last)
  );

endmodule

### tb/preemptive_priority_rr_scheduler_unit_test.sv
module preemptive_priority_rr_scheduler_unit_test;

  localparam int NTASK      = 16;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYC  = 100;
  localparam int N_RANDOM   = 410;

  typedef struct {
    logic [23:0] ev_time;
    logic [3:0]  ev_task;
    logic [1:0]  from_st;
    logic [2:0]  to_st;
    logic        last;
  } sched_event_t;

  typedef struct {
    logic         op;
    logic [3:0]   id;
    logic [15:0]  cpu;
    logic [15:0]  per;
    logic [15:0]  len;
    bit           typed;
    sched_event_t ev;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_op = pprs_pkg::OP_TICK;
  logic [3:0]  in_task_id = '0;
  logic [15:0] in_cpu_time = '0;
  logic [15:0] in_io_period = '0;
  logic [15:0] in_io_length = '0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        out_valid;
  logic [23:0] out_event_time;
  logic [3:0]  out_event_task;
  logic [1:0]  out_from_state;
  logic [2:0]  out_to_state;
  logic        out_last;

  preemptive_priority_rr_scheduler_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_task_id(in_task_id), .in_cpu_time(in_cpu_time),
    .in_io_period(in_io_period), .in_io_length(in_io_length),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_event_time(out_event_time),
    .out_event_task(out_event_task), .out_from_state(out_from_state),
    .out_to_state(out_to_state), .out_last(out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // scheduler shadow state
  logic [15:0] work_left [NTASK];
  logic [15:0] period_of [NTASK];
  logic [15:0] length_of [NTASK];
  logic [15:0] until_io  [NTASK];
  logic [15:0] io_remain [NTASK];
  logic [NTASK-1:0] ready_set = '0;
  logic [3:0]  io_queue [$];
  logic [3:0]  cur_task = '0;
  bit          cpu_on = 0;
  logic [15:0] quantum = '0;
  logic [23:0] sim_now = '0;
  logic [15:0] slice_len = pprs_pkg::TIME_SLICE_RST;

  sched_event_t transitions_q [$];
  int mismatches = 0;
  int idle_cycles = 0;

  task automatic note(input logic [3:0] t, input logic [2:0] f, input logic [2:0] to);
    sched_event_t e;
    e.ev_time = sim_now; e.ev_task = t; e.from_st = f[1:0]; e.to_st = to; e.last = 1'b0;
    transitions_q = {transitions_q, e};
  endtask

  // compute the transitions caused by one accepted beat
  task automatic schedule_step(input logic op, input logic [3:0] id, input logic [15:0] cpu,
                               input logic [15:0] per, input logic [15:0] len);
    int n0;
    int best;
    bit waiting;
    logic [3:0] keep [$];
    n0 = transitions_q.size();
    if (op == pprs_pkg::OP_ARRIVE) begin
      waiting = 0;
      foreach (io_queue[i]) if (io_queue[i] == id) waiting = 1;
      if (ready_set[id] || (cpu_on && cur_task == id) || waiting) return;
      work_left[id] = cpu; period_of[id] = per; length_of[id] = len;
      until_io[id] = per; io_remain[id] = '0;
      ready_set[id] = 1'b1;
      note(id, pprs_pkg::TS_NEW, pprs_pkg::TS_READY);
    end else begin
      // release finished waiters in queue order
      foreach (io_queue[i]) begin
        if (io_remain[io_queue[i]] > 0) io_remain[io_queue[i]]--;
        if (io_remain[io_queue[i]] == 0) begin
          ready_set[io_queue[i]] = 1'b1;
          note(io_queue[i], pprs_pkg::TS_WAIT, pprs_pkg::TS_READY);
        end else keep = {keep, io_queue[i]};
      end
      io_queue = keep;
      // charge the running task
      if (cpu_on) begin
        if (work_left[cur_task] > 0) work_left[cur_task]--;
        if (period_of[cur_task] > 0 && until_io[cur_task] > 0) until_io[cur_task]--;
        if (quantum != 16'hFFFF) quantum++;
        if (work_left[cur_task] == 0) begin
          note(cur_task, pprs_pkg::TS_RUN, pprs_pkg::TS_TERM);
          cpu_on = 0; quantum = '0;
        end else if (period_of[cur_task] > 0 && until_io[cur_task] == 0) begin
          note(cur_task, pprs_pkg::TS_RUN, pprs_pkg::TS_WAIT);
          io_remain[cur_task] = length_of[cur_task];
          until_io[cur_task] = period_of[cur_task];
          io_queue = {io_queue, cur_task};
          cpu_on = 0; quantum = '0;
        end
      end
      // dispatch lowest id ready task
      if (ready_set != '0) begin
        best = 0;
        while (!ready_set[best]) best++;
        if (!cpu_on || best < cur_task || quantum == slice_len) begin
          if (cpu_on) begin
            ready_set[cur_task] = 1'b1;
            note(cur_task, pprs_pkg::TS_RUN, pprs_pkg::TS_READY);
          end
          ready_set[best] = 1'b0;
          cur_task = best[3:0];
          cpu_on = 1;
          note(cur_task, pprs_pkg::TS_READY, pprs_pkg::TS_RUN);
          quantum = '0;
        end
      end
      sim_now = sim_now + 24'd1;
    end
    if (transitions_q.size() > n0) transitions_q[$].last = 1'b1;
  endtask

  // result checker
  always @(posedge clk) begin
    sched_event_t e;
    if (rst_n && out_valid) begin
      if (transitions_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: t=%0d task=%0d %0d->%0d last=%0d", out_event_time,
                   out_event_task, out_from_state, out_to_state, out_last);
      end else begin
        e = transitions_q.pop_front();
        if (out_event_time !== e.ev_time || out_event_task !== e.ev_task ||
            out_from_state !== e.from_st || out_to_state !== e.to_st ||
            out_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("mismatch: exp t=%0d task=%0d %0d->%0d last=%0d,",
                   e.ev_time, e.ev_task, e.from_st, e.to_st, e.last);
            $display(" got t=%0d task=%0d %0d->%0d last=%0d", out_event_time,
                     out_event_task, out_from_state, out_to_state, out_last);
          end
        end
      end
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[preemptive_priority_rr_scheduler_unit] ERROR");
      $finish;
    end
  end

  // drive one beat and wait for it to be taken; typed rows replace the prediction
  task automatic send_item(input stim_row_t r);
    int n0;
    @(negedge clk);
    start = 1'b1; in_op = r.op; in_task_id = r.id;
    in_cpu_time = r.cpu; in_io_period = r.per; in_io_length = r.len;
    do @(posedge clk); while (busy);
    n0 = transitions_q.size();
    schedule_step(r.op, r.id, r.cpu, r.per, r.len);
    if (r.typed) begin
      while (transitions_q.size() > n0) void'(transitions_q.pop_back());
      transitions_q = {transitions_q, r.ev};
    end
  endtask

  task automatic pause_random();
    int n;
    n = $urandom_range(1, 4);
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // wait for quiet, then load a new quantum
  task automatic write_slice(input logic [15:0] v);
    @(negedge clk);
    start = 1'b0;
    while (transitions_q.size() != 0 || busy) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    cfg_we = 1'b1; cfg_wdata = v;
    slice_len = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic stim_row_t arr(input logic [3:0] id, input logic [15:0] c,
                                    input logic [15:0] p, input logic [15:0] l);
    stim_row_t r;
    r.op = pprs_pkg::OP_ARRIVE; r.id = id; r.cpu = c; r.per = p; r.len = l; r.typed = 0;
    r.ev = '{default: '0};
    return r;
  endfunction

  function automatic stim_row_t tick();
    stim_row_t r;
    r = arr('0, '0, '0, '0);
    r.op = pprs_pkg::OP_TICK;
    return r;
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t r;
    r.op = ($urandom_range(0, 99) < 60) ? pprs_pkg::OP_TICK : pprs_pkg::OP_ARRIVE;
    r.id = 4'($urandom_range(0, 15));
    r.cpu = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
    r.per = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
    r.len = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    r.typed = 0;
    r.ev = '{default: '0};
    return r;
  endfunction

  stim_row_t directed [$];
  logic [15:0] slices [4] = '{16'd1, 16'hFFFF, 16'd3, 16'd0};

  initial begin
    stim_row_t r;
    int done;
    // directed table: extremes, duplicate arrival, zero work, zero i/o length
    r = arr(4'd0, 16'd3, 16'd0, 16'd0);
    r.typed = 1;
    r.ev = '{24'd0, 4'd0, pprs_pkg::TS_NEW[1:0], pprs_pkg::TS_READY, 1'b1};
    directed = {directed, r};
    r = arr(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    r.typed = 1;
    r.ev = '{24'd0, 4'd15, pprs_pkg::TS_NEW[1:0], pprs_pkg::TS_READY, 1'b1};
    directed = {directed, r};
    directed = {directed, arr(4'd0, 16'd9, 16'd9, 16'd9)};
    directed = {directed, tick()};
    directed = {directed, arr(4'd5, 16'd0, 16'd0, 16'd0)};
    directed = {directed, arr(4'd3, 16'd10, 16'd1, 16'd0)};
    repeat (4) directed = {directed, tick()};
    directed = {directed, arr(4'd7, 16'd5, 16'd2, 16'd3)};
    directed = {directed, arr(4'd10, 16'd1, 16'd0, 16'hFFFF)};
    repeat (12) directed = {directed, tick()};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send_item(directed[i]);

    // random phases, one quantum setting each
    done = 0;
    slices[3] = 16'($urandom_range(2, 65534));
    for (int ph = 0; ph < 4; ph++) begin
      write_slice(slices[ph]);
      repeat (N_RANDOM / 4) begin
        send_item(rand_row());
        done++;
        if (done < N_RANDOM * 85 / 100 && $urandom_range(0, 3) == 0) pause_random();
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (transitions_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0 && transitions_q.size() == 0)
      $display("[preemptive_priority_rr_scheduler_unit] OK");
    else
      $display("[preemptive_priority_rr_scheduler_unit] ERROR");
    $finish;
  end

endmodule
